### hw/rtl/pgpc_pkg.sv
// pgpc_pkg: shared types and constants for the prime-gcd pair counter.
// No dependencies.
package pgpc_pkg;
    localparam int TABLE_SIZE  = 65536;
    localparam int PRIME_SLOTS = 8192;
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int PIDX_W = $clog2(PRIME_SLOTS);
    localparam int LIM_W = 16;
    localparam int DIV_W = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_SV_INIT, ST_SV_TOP, ST_SV_PRIME, ST_SV_KRD, ST_SV_KWAIT,
        ST_SV_KCHK, ST_SV_DIV, ST_SV_MRD, ST_SV_MWAIT, ST_SV_MWR, ST_PF_RD,
        ST_PF_WAIT, ST_PF_WR, ST_IDLE, ST_Q_DIVA, ST_Q_DIVB, ST_Q_DIVH1,
        ST_Q_DIVH2, ST_Q_RD1, ST_Q_RD2, ST_Q_MUL1, ST_Q_MUL2, ST_Q_NEXT,
        ST_Q_DONE
    } state_t;

    // divider operands: n/i, m/i, n/a, m/b and the sieve's i/p
    typedef enum logic [2:0] {
        DSEL_NI, DSEL_MI, DSEL_NA, DSEL_MB, DSEL_IP
    } dsel_t;

    // controller -> datapath
    typedef struct packed {
        logic    clr_step;
        logic    sv_init;
        logic    sv_prime;
        logic    k_rd;
        logic    m_rd;
        logic    m_wr;
        logic    i_inc;
        logic    pf_rd;
        logic    pf_wr;
        logic    q_load;
        logic    div_start;
        dsel_t   div_arg;
        dsel_t   div_sel;
        logic    div_take;
        logic    rd1;
        logic    rd2;
        logic    mul1;
        logic    mul2;
        logic    q_next;
        logic    done;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic i_end;
        logic is_prime;
        logic k_end;
        logic k_break;
        logic k_divides;
        logic pf_last;
        logic div_done;
        logic q_empty;
        logic q_end;
    } sts_t;
endpackage

### hw/rtl/pgpc_divider.sv
// pgpc_divider: restoring divider, one quotient bit per cycle; gives quotient and remainder.
// Depends on pgpc_pkg.
module pgpc_divider
    import pgpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DIV_W:0] trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[DIV_W-1]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;
endmodule

### hw/rtl/pgpc_datapath.sv
// pgpc_datapath: sieve tables, prefix sums and the quotient-block walk.
// Depends on pgpc_pkg and pgpc_divider.
module pgpc_datapath
    import pgpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_t        ctl,
    input  logic [15:0] first_limit,
    input  logic [15:0] second_limit,
    output sts_t        sts,
    output logic [31:0] pair_count
);
    // memories
    logic              comp_mem [TABLE_SIZE];
    logic [15:0]       prime_mem [PRIME_SLOTS];
    logic [1:0]        mu_mem [TABLE_SIZE];
    logic [7:0]        w_mem [TABLE_SIZE];
    logic [31:0]       s_mem [TABLE_SIZE];

    logic [IDX_W:0]    clr_reg;
    logic [IDX_W:0]    i_reg;
    logic [PIDX_W:0]   ptot_reg;
    logic [PIDX_W:0]   k_reg;
    logic              comp_rd;
    logic [15:0]       p_rd;
    logic [1:0]        mui_reg;
    logic [7:0]        wi_reg;
    logic [IDX_W-1:0]  t_reg;
    logic              div_flag_reg;
    logic [31:0]       s_rd;
    logic [31:0]       sacc_reg;
    logic [IDX_W:0]    pf_reg;

    logic [15:0]       n_reg, m_reg;
    logic [16:0]       qi_reg, a_reg, b_reg, hi_reg;
    logic [31:0]       s_hi_reg, diff_reg, prod1_reg, acc_reg;

    logic [DIV_W-1:0]  dvd, dvs, quo, drem;
    logic              ddone;
    logic [31:0]       prod;
    logic [IDX_W-1:0]  i_idx;
    logic [15:0]       n_in, m_in;

    assign i_idx = i_reg[IDX_W-1:0];
    assign prod  = 32'(i_reg) * 32'(p_rd);

    // operands for the divide being launched; the first n/1 of a query
    // comes straight from the limits while they are loaded
    always_comb
    begin
        unique case (ctl.div_arg)
            DSEL_NI:
            begin
                dvd = ctl.q_load ? DIV_W'(n_in) : DIV_W'(n_reg);
                dvs = ctl.q_load ? DIV_W'(1) : qi_reg;
            end
            DSEL_MI: begin dvd = DIV_W'(m_reg); dvs = qi_reg; end
            DSEL_NA: begin dvd = DIV_W'(n_reg); dvs = a_reg; end
            DSEL_IP: begin dvd = i_reg; dvs = DIV_W'(p_rd); end
            default: begin dvd = DIV_W'(m_reg); dvs = b_reg; end
        endcase
    end

    pgpc_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
        .dividend(dvd), .divisor(dvs), .done(ddone), .quotient(quo),
        .remainder(drem)
    );

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            i_reg    <= '0;
            ptot_reg <= '0;
            k_reg    <= '0;
            pf_reg   <= '0;
        end
        else
        begin
            if (ctl.clr_step) clr_reg <= clr_reg + 1'b1;
            if (ctl.sv_init)
            begin
                i_reg  <= (IDX_W+1)'(2);
                pf_reg <= (IDX_W+1)'(1);
            end
            else if (ctl.i_inc)
                i_reg <= i_reg + 1'b1;
            if (ctl.sv_prime && ptot_reg < (PIDX_W+1)'(PRIME_SLOTS))
                ptot_reg <= ptot_reg + 1'b1;
            if (ctl.i_inc || ctl.sv_init) k_reg <= '0;
            else if (ctl.m_wr) k_reg <= k_reg + 1'b1;
            if (ctl.pf_wr) pf_reg <= pf_reg + 1'b1;
        end
    end

    // sieve memories, prefix sums and the query's table reads
    always_ff @(posedge clk)
    begin
        if (ctl.clr_step) comp_mem[clr_reg[IDX_W-1:0]] <= 1'b0;
        if (ctl.sv_init)
        begin
            mu_mem[1] <= 2'b01;
            w_mem[1]  <= 8'd0;
            s_mem[0]  <= 32'd0;
            sacc_reg  <= 32'd0;
        end
        comp_rd <= comp_mem[i_idx];
        if (ctl.sv_prime)
        begin
            if (ptot_reg < (PIDX_W+1)'(PRIME_SLOTS))
                prime_mem[ptot_reg[PIDX_W-1:0]] <= i_reg[15:0];
            mu_mem[i_idx] <= 2'b11;
            w_mem[i_idx]  <= 8'd1;
        end
        if (ctl.k_rd) p_rd <= prime_mem[k_reg[PIDX_W-1:0]];
        if (ctl.m_rd)
        begin
            mui_reg <= mu_mem[i_idx];
            wi_reg  <= w_mem[i_idx];
            t_reg   <= prod[IDX_W-1:0];
            div_flag_reg <= drem == '0;
        end
        if (ctl.m_wr)
        begin
            comp_mem[t_reg] <= 1'b1;
            if (!div_flag_reg)
            begin
                mu_mem[t_reg] <= 2'(-$signed(mui_reg));
                w_mem[t_reg]  <= 8'({{6{mui_reg[1]}}, mui_reg} - wi_reg);
            end
            else
            begin
                mu_mem[t_reg] <= 2'b00;
                w_mem[t_reg]  <= {{6{mui_reg[1]}}, mui_reg};
            end
        end
        if (ctl.pf_rd) wi_reg <= w_mem[pf_reg[IDX_W-1:0]];
        if (ctl.pf_wr)
        begin
            sacc_reg <= sacc_reg + {{24{wi_reg[7]}}, wi_reg};
            s_mem[pf_reg[IDX_W-1:0]] <= sacc_reg + {{24{wi_reg[7]}}, wi_reg};
        end
        if (ctl.rd1) s_rd <= s_mem[hi_reg[IDX_W-1:0]];
        if (ctl.rd2) s_rd <= s_mem[IDX_W'(qi_reg - 1'b1)];
    end

    // query walk
    assign n_in = (first_limit > second_limit) ? second_limit : first_limit;
    assign m_in = (first_limit > second_limit) ? first_limit : second_limit;

    always_ff @(posedge clk)
    begin
        if (ctl.q_load)
        begin
            n_reg   <= n_in;
            m_reg   <= m_in;
            qi_reg  <= 17'd1;
            acc_reg <= 32'd0;
        end
        if (ctl.div_take)
        begin
            unique case (ctl.div_sel)
                DSEL_NI: a_reg <= quo;
                DSEL_MI: b_reg <= quo;
                DSEL_NA: hi_reg <= quo;
                DSEL_MB: if (quo < hi_reg) hi_reg <= quo;
                default: ;
            endcase
        end
        if (ctl.rd2) s_hi_reg <= s_rd;
        if (ctl.mul1)
        begin
            diff_reg <= s_hi_reg - s_rd;
        end
        // next block start is ready before the next n/i launches
        if (ctl.mul2)
        begin
            prod1_reg <= 32'(diff_reg * 32'(a_reg));
            qi_reg    <= hi_reg + 1'b1;
        end
        if (ctl.q_next)
            acc_reg <= acc_reg + 32'(prod1_reg * 32'(b_reg));
        if (ctl.done) pair_count <= acc_reg;
    end

    // s_rd after rd1 is S(hi), captured on rd2 cycle; after rd2 it is S(i-1).
    assign sts.clr_last  = clr_reg == (IDX_W+1)'(TABLE_SIZE - 1);
    assign sts.i_end     = i_reg == (IDX_W+1)'(TABLE_SIZE);
    assign sts.is_prime  = !comp_rd;
    assign sts.k_end     = k_reg >= ptot_reg;
    assign sts.k_break   = prod >= 32'(TABLE_SIZE);
    assign sts.k_divides = div_flag_reg;
    assign sts.pf_last   = pf_reg == (IDX_W+1)'(TABLE_SIZE - 1);
    assign sts.div_done  = ddone;
    assign sts.q_empty   = n_in == 16'd0;
    assign sts.q_end     = (hi_reg + 1'b1) > {1'b0, n_reg};
endmodule

### hw/rtl/pgpc_controller.sv
// pgpc_controller: sequencer for table clearing, sieve, prefix pass and queries.
// Depends on pgpc_pkg.
module pgpc_controller
    import pgpc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output ctl_t ctl,
    output logic busy,
    output logic done
);
    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:    if (sts.clr_last) state_next = ST_SV_INIT;
            ST_SV_INIT:  state_next = ST_SV_TOP;
            ST_SV_TOP:   state_next = sts.i_end ? ST_PF_RD : ST_SV_PRIME;
            ST_SV_PRIME: state_next = ST_SV_KRD;
            ST_SV_KRD:   state_next = sts.k_end ? ST_SV_TOP : ST_SV_KWAIT;
            ST_SV_KWAIT: state_next = ST_SV_KCHK;
            ST_SV_KCHK:  state_next = sts.k_break ? ST_SV_TOP : ST_SV_DIV;
            ST_SV_DIV:   if (sts.div_done) state_next = ST_SV_MRD;
            ST_SV_MRD:   state_next = ST_SV_MWAIT;
            ST_SV_MWAIT: state_next = ST_SV_MWR;
            ST_SV_MWR:   state_next = sts.k_divides ? ST_SV_TOP : ST_SV_KRD;
            ST_PF_RD:    state_next = ST_PF_WAIT;
            ST_PF_WAIT:  state_next = ST_PF_WR;
            ST_PF_WR:    state_next = sts.pf_last ? ST_IDLE : ST_PF_RD;
            ST_IDLE:     if (start) state_next = sts.q_empty ? ST_Q_DONE : ST_Q_DIVA;
            ST_Q_DIVA:   if (sts.div_done) state_next = ST_Q_DIVB;
            ST_Q_DIVB:   if (sts.div_done) state_next = ST_Q_DIVH1;
            ST_Q_DIVH1:  if (sts.div_done) state_next = ST_Q_DIVH2;
            ST_Q_DIVH2:  if (sts.div_done) state_next = ST_Q_RD1;
            ST_Q_RD1:    state_next = ST_Q_RD2;
            ST_Q_RD2:    state_next = ST_Q_MUL1;
            ST_Q_MUL1:   state_next = ST_Q_MUL2;
            ST_Q_MUL2:   state_next = ST_Q_NEXT;
            ST_Q_NEXT:   state_next = sts.q_end ? ST_Q_DONE : ST_Q_DIVA;
            ST_Q_DONE:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // each divide state but the last (ST_Q_DIVH2) takes its quotient and launches
    // the next divide in the same cycle
    always_comb
    begin
        ctl = '0;
        ctl.div_sel = DSEL_NI;
        ctl.div_arg = DSEL_NI;
        unique case (state_reg)
            ST_CLEAR:    ctl.clr_step = 1'b1;
            ST_SV_INIT:  ctl.sv_init = 1'b1;
            ST_SV_TOP:   ;
            ST_SV_PRIME: ctl.sv_prime = sts.is_prime;
            ST_SV_KRD:
            begin
                ctl.k_rd = 1'b1;
                ctl.i_inc = sts.k_end;
            end
            ST_SV_KWAIT: ;
            ST_SV_KCHK:
            begin
                // i mod p decides whether p is the smallest factor of i
                ctl.i_inc = sts.k_break;
                ctl.div_arg = DSEL_IP;
                ctl.div_start = !sts.k_break;
            end
            ST_SV_DIV:   ctl.m_rd = sts.div_done;
            ST_SV_MRD:   ;
            ST_SV_MWAIT: ;
            ST_SV_MWR:
            begin
                ctl.m_wr = 1'b1;
                ctl.i_inc = sts.k_divides;
            end
            ST_PF_RD:    ctl.pf_rd = 1'b1;
            ST_PF_WAIT:  ;
            ST_PF_WR:    ctl.pf_wr = 1'b1;
            ST_IDLE:
            begin
                ctl.q_load = start;
                ctl.div_start = start && !sts.q_empty;
            end
            ST_Q_DIVA:
            begin
                ctl.div_sel = DSEL_NI;
                ctl.div_take = sts.div_done;
                ctl.div_arg = DSEL_MI;
                ctl.div_start = sts.div_done;
            end
            ST_Q_DIVB:
            begin
                ctl.div_sel = DSEL_MI;
                ctl.div_take = sts.div_done;
                ctl.div_arg = DSEL_NA;
                ctl.div_start = sts.div_done;
            end
            ST_Q_DIVH1:
            begin
                ctl.div_sel = DSEL_NA;
                ctl.div_take = sts.div_done;
                ctl.div_arg = DSEL_MB;
                ctl.div_start = sts.div_done;
            end
            ST_Q_DIVH2:
            begin
                ctl.div_sel = DSEL_MB;
                ctl.div_take = sts.div_done;
            end
            ST_Q_RD1:    ctl.rd1 = 1'b1;
            ST_Q_RD2:    ctl.rd2 = 1'b1;
            ST_Q_MUL1:   ctl.mul1 = 1'b1;
            ST_Q_MUL2:   ctl.mul2 = 1'b1;
            ST_Q_NEXT:
            begin
                ctl.q_next = 1'b1;
                ctl.div_start = !sts.q_end;
            end
            ST_Q_DONE:   ctl.done = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_CLEAR;
        else        state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done <= 1'b0;
        else        done <= ctl.done;
    end

    assign busy = state_reg != ST_IDLE;
endmodule

### hw/rtl/prime_gcd_pair_counter_top.sv
// prime_gcd_pair_counter_top: top level of the prime-gcd pair counter.
// Depends on pgpc_pkg, pgpc_controller, pgpc_datapath.
//
// After reset the block clears its composite marks, runs a linear sieve over
// 2..65535 (each marking step includes a divide that tests i mod p), then
// forms prefix sums of the prime weights; busy stays high for all of start-up.
// A query word is taken when start is high and busy is low. It walks the blocks
// of equal quotients: each block takes four divides on the single shared divider
// plus table reads, multiplies and accumulation. A query walks at most about
// 2*(sqrt(n)+sqrt(m)) blocks; a zero limit skips the walk.
// pair_count is shown for one cycle with done high; the receiver cannot stall.
module prime_gcd_pair_counter_top
    import pgpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] first_limit,
    input  logic [15:0] second_limit,
    output logic        busy,
    output logic        done,
    output logic [31:0] pair_count
);
    ctl_t ctl;
    sts_t sts;

    pgpc_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .sts(sts),
        .ctl(ctl), .busy(busy), .done(done)
    );

    pgpc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .first_limit(first_limit), .second_limit(second_limit),
        .sts(sts), .pair_count(pair_count)
    );
endmodule

### tb/tb_prime_gcd_pair_counter_top.sv
// tb_prime_gcd_pair_counter_top: self-checking testbench for the prime-gcd pair counter.
// Depends on pgpc_pkg and prime_gcd_pair_counter_top; it keeps its own sieve tables
// and counts pairs in software.
module tb_prime_gcd_pair_counter_top
    import pgpc_pkg::*;
();

    // Expected pair counts wait here in query order. The block gives one word per query.
    class pair_count_board;
        logic [31:0] counts_due[$];
        int          fails;
        int          checked;

        function new();
            fails = 0;
            checked = 0;
        endfunction

        function void note_query(logic [31:0] want);
            counts_due.push_back(want);
        endfunction

        function void check_count(logic [31:0] got);
            logic [31:0] want;
            if (counts_due.size() == 0)
            begin
                $error("pair_count %0d arrived with no query pending", got);
                fails++;
                return;
            end
            want = counts_due.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("pair_count mismatch: expected %0d, actual %0d", want, got);
                fails++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [15:0] first_limit = '0;
    logic [15:0] second_limit = '0;
    logic        busy;
    logic        done;
    logic [31:0] pair_count;

    pair_count_board board = new();

    // Tables of the sieve: composite flags, primes, Mobius values, weights, prefix sums.
    bit          not_prime[TABLE_SIZE];
    int          primes[$];
    int          mu[TABLE_SIZE];
    int          gw[TABLE_SIZE];
    int          gw_sum[TABLE_SIZE];
    int          idle_pct;
    int          large_queries;

    prime_gcd_pair_counter_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .first_limit  (first_limit),
        .second_limit (second_limit),
        .busy         (busy),
        .done         (done),
        .pair_count   (pair_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Linear sieve: each composite is marked once, by its smallest prime factor.
    // The weight of d is the sum of mu(d/p) over the primes p that divide d.
    task automatic build_tables();
        int i;
        int k;
        int p;
        int t;
        mu[1] = 1;
        gw[1] = 0;
        for (i = 2; i < TABLE_SIZE; i++)
        begin
            if (!not_prime[i])
            begin
                if (primes.size() < PRIME_SLOTS)
                    primes.push_back(i);
                mu[i] = -1;
                gw[i] = 1;
            end
            for (k = 0; k < primes.size(); k++)
            begin
                p = primes[k];
                if (longint'(i) * p >= TABLE_SIZE)
                    break;
                t = i * p;
                not_prime[t] = 1'b1;
                if (i % p != 0)
                begin
                    mu[t] = -mu[i];
                    gw[t] = mu[i] - gw[i];
                end
                else
                begin
                    // p already divides i: mu vanishes, and only p itself adds to the weight
                    mu[t] = 0;
                    gw[t] = mu[i];
                    break;
                end
            end
        end
        gw_sum[0] = 0;
        for (i = 1; i < TABLE_SIZE; i++)
            gw_sum[i] = gw_sum[i - 1] + gw[i];
    endtask

    // Count of pairs with a prime gcd: a walk over the runs of i where n/i and m/i stay fixed.
    function automatic logic [31:0] prime_gcd_pairs(logic [15:0] lim_a, logic [15:0] lim_b);
        int     n;
        int     m;
        int     i;
        int     hi;
        int     h2;
        int     qa;
        int     qb;
        longint acc;
        n = (lim_a < lim_b) ? lim_a : lim_b;
        m = (lim_a < lim_b) ? lim_b : lim_a;
        if (n > TABLE_SIZE - 1)
            n = TABLE_SIZE - 1;
        if (m > TABLE_SIZE - 1)
            m = TABLE_SIZE - 1;
        acc = 0;
        for (i = 1; i <= n; i = hi + 1)
        begin
            qa = n / i;
            qb = m / i;
            hi = n / qa;
            h2 = m / qb;
            if (h2 < hi)
                hi = h2;
            acc += longint'(gw_sum[hi] - gw_sum[i - 1]) * qa * qb;
        end
        return acc[31:0];
    endfunction

    // A query is taken at an edge where start is high and busy is low.
    // done marks a one-cycle result that cannot be held off.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.note_query(prime_gcd_pairs(first_limit, second_limit));
        if (rst_n && done)
            board.check_count(pair_count);
    end

    // start stays high from one word to the next when there is no gap,
    // so it gets only one assignment in a time step.
    task automatic send_query(logic [15:0] a, logic [15:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        first_limit  <= a;
        second_limit <= b;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Mostly short limits keep the run brief. About one query in ten spans the
    // full 16-bit range, so every bit of each limit goes both ways.
    task automatic send_random_query();
        logic [15:0] a;
        logic [15:0] b;
        if ($urandom_range(9) == 0)
        begin
            a = $urandom_range(65535, 1);
            b = $urandom_range(65535, 1);
            large_queries++;
        end
        else
        begin
            a = $urandom_range(1023, 1);
            b = $urandom_range(1023, 1);
        end
        send_query(a, b);
    endtask

    initial
    begin
        int n;
        large_queries = 0;
        idle_pct = 22;
        build_tables();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: zero limits, ones, the swap in both directions, the
        // full range, and alternating bit patterns.
        send_query(16'd0, 16'd0);
        send_query(16'd0, 16'd5);
        send_query(16'd5, 16'd0);
        send_query(16'd1, 16'd1);
        send_query(16'd2, 16'd3);
        send_query(16'd3, 16'd2);
        send_query(16'd7, 16'd7);
        send_query(16'd12, 16'd18);
        send_query(16'd100, 16'd50);
        send_query(16'd1000, 16'd1);
        send_query(16'd1, 16'd65535);
        send_query(16'd65535, 16'd1);
        send_query(16'hAAAA, 16'h5555);
        send_query(16'h5555, 16'hAAAA);
        send_query(16'd65535, 16'd65535);

        // The sender's idling goes from light to heavy to none across three phases.
        for (n = 0; n < 34; n++)
            send_random_query();
        idle_pct = 71;
        for (n = 0; n < 33; n++)
            send_random_query();
        idle_pct = 0;
        for (n = 0; n < 33; n++)
            send_random_query();
        start <= 1'b0;

        while (board.counts_due.size() != 0)
            @(posedge clk);
        // a stray extra done would show up within this margin
        repeat (200) @(posedge clk);

        $display("Checked %0d pair counts from 15 directed and 100 random queries",
                 board.checked);
        $display("(%0d random ones over the full range), with sender gaps of 22%%, 71%%, 0%%",
                 large_queries);
        if (board.fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Start-up (clearing, sieve, prefix sums) comes before any query. This bound is several
    // times the time of start-up and all queries, even if every query spanned the full range.
    initial
    begin
        #600000000;
        $display("Timeout: %0d pair counts still pending", board.counts_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
